// File: hw/rtl/stlm_pkg.sv
// ----------------------------------------------------------------------------
// stlm_pkg
// Shared types and constants for the stable two-list merge unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stlm_pkg;

  // Default number of entries held by each list.
  localparam int unsigned LIST_DEPTH_DEF = 32;

  // Width of a stored value. The payload structs fix it.
  localparam int unsigned VALUE_WIDTH = 32;

  localparam int unsigned MODE_WIDTH = 2;

  // Command codes carried in the mode field.
  localparam logic [MODE_WIDTH-1:0] MODE_LOAD_FIRST  = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_LOAD_SECOND = 2'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_MERGE       = 2'd2;

  typedef struct packed {
    logic [MODE_WIDTH-1:0]         mode;
    logic signed [VALUE_WIDTH-1:0] value;
  } cmd_word_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] merged_value;
    logic                          from_second;
    logic                          last;
  } res_word_t;

endpackage

`default_nettype wire

// File: hw/rtl/stable_two_list_merge_unit.sv
// ----------------------------------------------------------------------------
// stable_two_list_merge_unit
// Collects two sorted lists in two local memories and emits them as one
// stable, non-decreasing merged sequence.
// ----------------------------------------------------------------------------
//
//   Channel | Signals                    | Carries
//   --------+----------------------------+-------------------------------------
//   cmd     | cmd_valid, cmd_ready, cmd  | load to first/second list, or merge
//   res     | res_valid, res_ready, res  | merged value, source list, last flag
//
// Loads can be accepted back to back.
// A merge keeps cmd_ready low while it walks both memories, one result per
// cycle unless the consumer stalls; the first result is registered once the
// state has entered the merge state, from the registered memory read data.
// A merge with both lists empty gives no result.
// Reset clears the counts and the control state only; memory contents are
// left as they are, since an entry is only read after it has been written.
// A stalled result simply holds the walk: indices and read addresses stay put.
//
`timescale 1ns / 1ps
`default_nettype none

module stable_two_list_merge_unit #(
  parameter int unsigned LIST_DEPTH = stlm_pkg::LIST_DEPTH_DEF
) (
  input  wire                      clk,
  input  wire                      rst,

  input  wire                      cmd_valid,
  output logic                     cmd_ready,
  input  wire stlm_pkg::cmd_word_t cmd,

  output logic                     res_valid,
  input  wire                      res_ready,
  output stlm_pkg::res_word_t      res
);

  // Address width for indexing a memory, and count width able to hold the
  // depth itself. A sum of two counts needs one bit more.
  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned VW = stlm_pkg::VALUE_WIDTH;

  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_MERGE = 2'b10
  } state_t;

  state_t state, state_next;

  // Fill levels of the two lists.
  logic [CW-1:0] first_count, first_count_next;
  logic [CW-1:0] second_count, second_count_next;

  // Head indices used during a merge.
  logic [CW-1:0] first_idx, first_idx_next;
  logic [CW-1:0] second_idx, second_idx_next;

  // The two list memories with their registered read data.
  logic [VW-1:0] first_mem  [LIST_DEPTH];
  logic [VW-1:0] second_mem [LIST_DEPTH];
  logic [VW-1:0] first_head, second_head;
  logic [AW-1:0] first_raddr, second_raddr;

  logic          cmd_fire;
  logic          load_first, load_second, merge_start;
  logic          res_load;
  logic          take_second;
  logic          emit_last;
  logic [SW-1:0] emitted_sum, total_sum;

  assign cmd_ready = (state == ST_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;

  // Loads to a full list are dropped; the count saturates at the depth.
  assign load_first  = cmd_fire && (cmd.mode == stlm_pkg::MODE_LOAD_FIRST)
                       && (first_count < DEPTH_C);
  assign load_second = cmd_fire && (cmd.mode == stlm_pkg::MODE_LOAD_SECOND)
                       && (second_count < DEPTH_C);
  assign merge_start = cmd_fire && (cmd.mode == stlm_pkg::MODE_MERGE);

  // The output register may take a new word when it is empty or being drained.
  assign res_load = (state == ST_MERGE) && (!res_valid || res_ready);

  // Head selection: the second list wins only when the first is used up or
  // its head is strictly smaller, which keeps equal values in first-list
  // order and so makes the merge stable.
  always_comb begin
    if (first_idx >= first_count) begin
      take_second = 1'b1;
    end else if ((second_idx < second_count)
                 && ($signed(second_head) < $signed(first_head))) begin
      take_second = 1'b1;
    end else begin
      take_second = 1'b0;
    end
  end

  // The word being emitted is the last when it brings the number emitted up
  // to the combined length of both lists.
  assign emitted_sum = SW'(first_idx) + SW'(second_idx) + SW'(1);
  assign total_sum   = SW'(first_count) + SW'(second_count);
  assign emit_last   = (emitted_sum == total_sum);

  always_comb begin
    state_next        = state;
    first_count_next  = first_count;
    second_count_next = second_count;
    first_idx_next    = first_idx;
    second_idx_next   = second_idx;

    unique case (state)
      ST_IDLE: begin
        first_idx_next  = '0;
        second_idx_next = '0;
        if (load_first) begin
          first_count_next = first_count + CW'(1);
        end
        if (load_second) begin
          second_count_next = second_count + CW'(1);
        end
        // An empty merge produces nothing and leaves the counts at zero.
        if (merge_start && ((first_count != '0) || (second_count != '0))) begin
          state_next = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (res_load) begin
          if (take_second) begin
            second_idx_next = second_idx + CW'(1);
          end else begin
            first_idx_next = first_idx + CW'(1);
          end
          if (emit_last) begin
            state_next        = ST_IDLE;
            first_count_next  = '0;
            second_count_next = '0;
            first_idx_next    = '0;
            second_idx_next   = '0;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      first_count  <= '0;
      second_count <= '0;
      first_idx    <= '0;
      second_idx   <= '0;
    end else begin
      state        <= state_next;
      first_count  <= first_count_next;
      second_count <= second_count_next;
      first_idx    <= first_idx_next;
      second_idx   <= second_idx_next;
    end
  end

  // Read addresses follow the next head indices, so the registered read data
  // always holds the current heads. An index that has run past the depth
  // reads entry zero; that head is never chosen.
  assign first_raddr  = (first_idx_next < DEPTH_C) ? first_idx_next[AW-1:0] : '0;
  assign second_raddr = (second_idx_next < DEPTH_C) ? second_idx_next[AW-1:0] : '0;

  // Writes happen only while idle and reads that matter only while merging;
  // the last load is written before the first merge read, so the two never
  // touch the same entry in the same cycle.
  always_ff @(posedge clk) begin
    if (load_first) begin
      first_mem[first_count[AW-1:0]] <= cmd.value;
    end
    first_head <= first_mem[first_raddr];
  end

  always_ff @(posedge clk) begin
    if (load_second) begin
      second_mem[second_count[AW-1:0]] <= cmd.value;
    end
    second_head <= second_mem[second_raddr];
  end

  // Output register: parts the merge walk from the consumer, so loads are
  // still taken while the final result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.merged_value <= take_second ? second_head : first_head;
      res.from_second  <= take_second;
      res.last         <= emit_last;
    end
  end

`ifndef SYNTHESIS
  // The counts never run past the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (first_count <= DEPTH_C) && (second_count <= DEPTH_C))
    else $error("list count beyond depth");

  // While merging there is always at least one element left to emit.
  a_merge_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MERGE) |->
      ((first_idx < first_count) || (second_idx < second_count)))
    else $error("merge running with both lists exhausted");

  // Emitting the last word ends the merge and empties both lists.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (res_load && emit_last) |=>
      ((state == ST_IDLE) && (first_count == '0) && (second_count == '0)))
    else $error("merge did not finish after last word");
`endif

endmodule

`default_nettype wire
